FILE: rtl/nth_permutation_unrank_defines.svh
// Assertion macros used by the checker file of the permutation unranking block
`ifndef NTH_PERMUTATION_UNRANK_DEFINES_SVH
`define NTH_PERMUTATION_UNRANK_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define NPU_ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define NPU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/npu_pkg.sv
// Package: constants, state type and factorial table for the permutation unranking block
package npu_pkg;

    localparam int MAX_LEN_DEF = 16;
    localparam int ELEM_W      = 32;
    localparam int RANK_W      = 64;
    localparam int FACT_IW     = 5;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_DIG,
        ST_SUB,
        ST_ROT_HI,
        ST_ROT_HD,
        ST_ROT,
        ST_OUT_RD,
        ST_OUT_SHOW
    } t_state;

    // n! for n = 0..20; 20! is the largest that fits in 64 bits
    function automatic logic [RANK_W-1:0] fact_of(input logic [FACT_IW-1:0] n);
        logic [RANK_W-1:0] f;
        case (n)
            5'd0:    f = 64'd1;
            5'd1:    f = 64'd1;
            5'd2:    f = 64'd2;
            5'd3:    f = 64'd6;
            5'd4:    f = 64'd24;
            5'd5:    f = 64'd120;
            5'd6:    f = 64'd720;
            5'd7:    f = 64'd5040;
            5'd8:    f = 64'd40320;
            5'd9:    f = 64'd362880;
            5'd10:   f = 64'd3628800;
            5'd11:   f = 64'd39916800;
            5'd12:   f = 64'd479001600;
            5'd13:   f = 64'd6227020800;
            5'd14:   f = 64'd87178291200;
            5'd15:   f = 64'd1307674368000;
            5'd16:   f = 64'd20922789888000;
            5'd17:   f = 64'd355687428096000;
            5'd18:   f = 64'd6402373705728000;
            5'd19:   f = 64'd121645100408832000;
            5'd20:   f = 64'd2432902008176640000;
            default: f = 64'd1;
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/npu_store.sv
// Vector store: one write port, one read port, registered read data
module npu_store
    import npu_pkg::*;
#(
    parameter int DEPTH = MAX_LEN_DEF,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [ELEM_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [ELEM_W-1:0] o_rdata
);

    logic [ELEM_W-1:0] r_mem [0:DEPTH-1];
    logic [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/npu_mod.sv
// Bit-serial 64-bit remainder unit, one quotient bit per cycle
module npu_mod
    import npu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RANK_W-1:0] i_dividend,
    input  logic [RANK_W-1:0] i_divisor,
    output logic              o_done,
    output logic [RANK_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(RANK_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RANK_W-1:0] r_rem;
    logic [RANK_W-1:0] r_q;
    logic [RANK_W-1:0] r_div;
    logic [RANK_W:0]   n_trial;
    logic [RANK_W:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_q[RANK_W-1]};
        n_diff  = n_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= CNT_W'(RANK_W - 1);
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits in RANK_W bits
            if (!n_diff[RANK_W]) begin
                r_rem <= n_diff[RANK_W-1:0];
            end else begin
                r_rem <= n_trial[RANK_W-1:0];
            end
            r_q   <= {r_q[RANK_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/nth_permutation_unrank.sv
// Load: one element per cycle while the source is valid. After the last element the rank is reduced mod L!,
// then each position gets a digit search by repeated subtraction and, for a nonzero digit, a rotation.
// Output: each result is read from the store and shown until taken; the next vector is taken after the final result.
// The bit-serial 64-bit remainder unit and the element-by-element store rotation set the unrank time.
// Synchronous active-low reset clears the controller, element count and overflow flag;
// store contents are not cleared.
module nth_permutation_unrank
    import npu_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // [31:0] element, [95:32] rank
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // [31:0] element_res
    output logic         m_axis_tlast,
    output logic         m_axis_tuser    // [0] too_long
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_state            r_state;
    t_state            n_state;

    logic [CW-1:0]     r_cnt;
    logic              r_ovf;
    logic [CW-1:0]     r_len;
    logic              r_tl;
    logic [RANK_W-1:0] r_rank;
    logic [RANK_W-1:0] r_w;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_d;
    logic [CW-1:0]     r_hi;
    logic [CW-1:0]     r_k;
    logic [ELEM_W-1:0] r_hold;

    logic              s_acc;
    logic              m_acc;
    logic              room;
    logic [CW-1:0]     n_cnt;
    logic              n_ovf;
    logic              sub_ok;
    logic [RANK_W:0]   sub_diff;
    logic              out_last;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ELEM_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [ELEM_W-1:0] mem_rdata;

    logic              mod_start;
    logic              mod_done;
    logic [RANK_W-1:0] mod_rem;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign m_acc    = m_axis_tvalid && m_axis_tready;
    assign room     = r_cnt < CW'(MAX_LEN);
    assign n_cnt    = room ? CW'(r_cnt + 1'b1) : r_cnt;
    assign n_ovf    = r_ovf | ~room;
    assign sub_diff = {1'b0, r_rank} - {1'b0, r_w};
    assign sub_ok   = !sub_diff[RANK_W];
    assign out_last = r_k == CW'(r_len - 1'b1);

    npu_store #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    npu_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_rank),
        .i_divisor  (r_w),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mod_start     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_cnt[AW-1:0];
        mem_wdata     = s_axis_tdata[ELEM_W-1:0];
        mem_re        = 1'b0;
        mem_raddr     = r_k[AW-1:0];
        unique case (r_state)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                mem_we        = s_axis_tvalid && room;
                if (s_axis_tvalid && s_axis_tlast) begin
                    n_state = ST_MOD_GO;
                end
            end
            ST_MOD_GO: begin
                mod_start = 1'b1;
                n_state   = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (mod_done) begin
                    n_state = ST_DIG;
                end
            end
            ST_DIG: begin
                if (r_i == r_len || r_rank == '0) begin
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                if (!sub_ok) begin
                    n_state = (r_d == '0) ? ST_DIG : ST_ROT_HI;
                end
            end
            ST_ROT_HI: begin
                mem_re    = 1'b1;
                mem_raddr = r_hi[AW-1:0];
                n_state   = ST_ROT_HD;
            end
            ST_ROT_HD: begin
                mem_re  = 1'b1;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                // write back the element from one place lower, fetch the next
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
                mem_wdata = r_hold;
                if (r_k == r_hi) begin
                    n_state = ST_DIG;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_k + 1'b1);
                end
            end
            ST_OUT_RD: begin
                mem_re  = 1'b1;
                n_state = ST_OUT_SHOW;
            end
            ST_OUT_SHOW: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = out_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // element count and overflow flag of the vector being loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (s_acc) begin
            if (s_axis_tlast) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                if (s_acc && s_axis_tlast) begin
                    r_len  <= n_cnt;
                    r_tl   <= n_ovf;
                    r_rank <= s_axis_tdata[ELEM_W +: RANK_W];
                    r_w    <= fact_of(FACT_IW'(n_cnt));
                end
            end
            ST_MOD_WAIT: begin
                if (mod_done) begin
                    r_rank <= mod_rem;
                    r_i    <= '0;
                end
            end
            ST_DIG: begin
                r_w <= fact_of(FACT_IW'(CW'(r_len - r_i - 1'b1)));
                r_d <= '0;
            end
            ST_SUB: begin
                // digit search by repeated subtraction of the place weight
                if (sub_ok) begin
                    r_rank <= sub_diff[RANK_W-1:0];
                    r_d    <= CW'(r_d + 1'b1);
                end else if (r_d == '0) begin
                    r_i <= CW'(r_i + 1'b1);
                end else begin
                    r_hi <= CW'(r_i + r_d);
                end
            end
            ST_ROT_HI: begin
                r_k <= r_i;
            end
            ST_ROT_HD: begin
                r_hold <= mem_rdata;
            end
            ST_ROT: begin
                r_hold <= mem_rdata;
                if (r_k == r_hi) begin
                    r_i <= CW'(r_i + 1'b1);
                    r_k <= '0;
                end else begin
                    r_k <= CW'(r_k + 1'b1);
                end
            end
            ST_OUT_SHOW: begin
                if (m_acc) begin
                    r_k <= CW'(r_k + 1'b1);
                end
            end
            default: begin
            end
        endcase
        // the output sweep starts at position zero
        if (r_state == ST_DIG && (r_i == r_len || r_rank == '0)) begin
            r_k <= '0;
        end
    end

    assign m_axis_tdata = mem_rdata;
    assign m_axis_tlast = out_last;
    assign m_axis_tuser = r_tl;

endmodule

FILE: rtl/npu_checker.sv
// Port-level checker for the permutation unranking block, bound to the top level
`include "nth_permutation_unrank_defines.svh"

module npu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    `NPU_ASSERT_NEVER(a_no_load_while_out, i_clk, i_rst_n, m_axis_tvalid && s_axis_tready, "input ready while a result is shown")
    `NPU_ASSERT_HOLD(a_last_in_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready && !m_axis_tvalid, "block not busy after end of vector")
    `NPU_ASSERT_HOLD(a_last_out_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid, "block not back to loading after final result")
    `NPU_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind nth_permutation_unrank npu_checker u_npu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/nth_permutation_unrank_tb.sv
// Testbench for the permutation unranking block: directed, random and back-pressure tests
module nth_permutation_unrank_tb;
    import npu_pkg::*;

    localparam int MAX_LEN     = MAX_LEN_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic              last;
        logic              too_long;
    } perm_out_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [95:0]        s_axis_tdata = '0;   // [31:0] element, [95:32] rank
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;        // [31:0] element_res
    logic               m_axis_tlast;
    logic               m_axis_tuser;        // [0] too_long

    // predictor state
    logic [ELEM_W-1:0]  vec_model [MAX_LEN];
    int                 load_model = 0;
    logic               drop_model = 1'b0;
    perm_out_t          perm_expected [$];

    int                 error_cnt = 0;
    int                 cycle_cnt = 0;
    int                 src_idle_pct = 0;
    int                 snk_stall_pct = 0;
    int                 hold_token = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;

    nth_permutation_unrank uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [RANK_W-1:0] factorial(input int n);
        logic [RANK_W-1:0] f;
        f = 64'd1;
        for (int k = 2; k <= n; k++)
            f = f * k;
        return f;
    endfunction

    // Store one element; on the last one, unrank and queue the permuted vector.
    task automatic predict_perm(input logic [ELEM_W-1:0] elem, input logic [RANK_W-1:0] rank,
                                input logic last);
        logic [RANK_W-1:0] rem;
        logic [RANK_W-1:0] w;
        logic [RANK_W-1:0] d;
        logic [ELEM_W-1:0] carry;
        int                len;
        int                hi;
        perm_out_t         r;
        if (load_model < MAX_LEN) begin
            vec_model[load_model] = elem;
            load_model++;
        end else begin
            drop_model = 1'b1;
        end
        if (last) begin
            len = load_model;
            rem = rank % factorial(len);
            for (int i = 0; i < len && rem != 0; i++) begin
                w   = factorial(len - i - 1);
                d   = rem / w;
                rem = rem - d * w;
                hi  = i + int'(d);
                carry = vec_model[hi];
                for (int k = hi; k > i; k--)
                    vec_model[k] = vec_model[k-1];
                vec_model[i] = carry;
            end
            for (int k = 0; k < len; k++) begin
                r.elem     = vec_model[k];
                r.last     = (k == len - 1);
                r.too_long = drop_model;
                perm_expected.push_back(r);
            end
            load_model = 0;
            drop_model = 1'b0;
        end
    endtask

    // One transaction on the input side, with random idle cycles before it.
    task automatic send_item(input logic [ELEM_W-1:0] elem, input logic [RANK_W-1:0] rank,
                             input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rank, elem};
        s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predict_perm(elem, rank, last);
    endtask

    function automatic logic [RANK_W-1:0] pick_rank(input int len);
        int                sel;
        int                eff;
        logic [RANK_W-1:0] lf;
        sel = $urandom_range(99);
        eff = (len > MAX_LEN) ? MAX_LEN : len;
        lf  = factorial(eff);
        if (sel < 45)
            return {$urandom, $urandom};
        else if (sel < 75)
            return {$urandom, $urandom} % lf;
        else if (sel < 85)
            return '0;
        else if (sel < 92)
            return lf - 1;
        else if (sel < 96)
            return lf;
        else
            return '1;
    endfunction

    task automatic send_random_vector(input int len);
        logic [ELEM_W-1:0] v;
        bit                ascending;
        ascending = ($urandom_range(99) < 70);
        v = $urandom;
        for (int k = 0; k < len; k++) begin
            if (!ascending)
                v = $urandom;
            else if (k > 0)
                v = v + $urandom_range(0, 1000);
            // rank on non-last items is noise
            send_item(v, (k == len - 1) ? pick_rank(len) : {$urandom, $urandom},
                      k == len - 1);
        end
    endtask

    task automatic test_single_element;
        send_item(32'hFFFF_FFFF, '1, 1'b1);
    endtask

    task automatic test_rank_wrap;
        // three elements, last permutation
        send_item(32'd1, {$urandom, $urandom}, 1'b0);
        send_item(32'd2, {$urandom, $urandom}, 1'b0);
        send_item(32'd3, 64'd5, 1'b1);
        // rank equal to L! wraps to identity
        send_item(32'd0, '1, 1'b0);
        send_item(32'hFFFF_FFFF, 64'd2, 1'b1);
    endtask

    task automatic test_full_vector;
        for (int k = 0; k < MAX_LEN; k++)
            send_item(32'h1111_1111 * k, factorial(MAX_LEN) - 1, k == MAX_LEN - 1);
    endtask

    // one element past capacity, its last mark still closes the vector
    task automatic test_overflow;
        send_random_vector(MAX_LEN + 1);
        send_random_vector(20);
    endtask

    task automatic test_random(input int n_items, input int src_pct, input int snk_pct);
        int sent;
        int len;
        int sel;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(99);
            if (sel < 70)
                len = $urandom_range(1, 8);
            else if (sel < 92)
                len = $urandom_range(9, MAX_LEN);
            else
                len = $urandom_range(MAX_LEN + 1, 20);
            send_random_vector(len);
            sent += len;
        end
    endtask

    // Receiver holds off while the sender keeps offering vectors.
    task automatic test_backpressure;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_token++;
        for (int n = 0; n < 3; n++)
            send_random_vector(8);
    endtask

    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        perm_out_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (perm_expected.size() == 0) begin
                error_cnt++;
                $display("%0t: unexpected transaction: expected none, got elem %h last %b too_long %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = perm_expected.pop_front();
                if (m_axis_tdata !== want.elem || m_axis_tlast !== want.last ||
                    m_axis_tuser !== want.too_long) begin
                    error_cnt++;
                    $display("%0t: mismatch: expected elem %h last %b too_long %b, got elem %h last %b too_long %b",
                             $time, want.elem, want.last, want.too_long,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_element();
        test_rank_wrap();
        test_full_vector();
        test_overflow();
        test_random(95, 0, 0);
        test_random(95, 49, 0);
        test_random(95, 0, 49);
        test_random(95, 21, 21);
        test_backpressure();

        s_axis_tvalid <= 1'b0;
        while (perm_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
